[rtl/core/sbb_pkg.sv]
// Package for the Bellman backup core: table geometry, field widths,
// item kind codes and the saturating helper. No dependencies.
package sbb_pkg;

	localparam int NUM_STATES  = 1024;
	localparam int MAX_ACTIONS = 16;

	localparam int STATE_W   = 10;
	localparam int VALUE_W   = 32;
	localparam int PROB_W    = 17;
	localparam int ACTION_W  = 4;
	localparam int PROB_SHIFT = 16;

	localparam int ADDR_W = $clog2(NUM_STATES);
	localparam int FULL_W = VALUE_W + PROB_W;
	localparam int PROD_W = FULL_W - PROB_SHIFT;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic [ACTION_W-1:0] ACT_LIMIT =
		ACTION_W'((MAX_ACTIONS < 16) ? (MAX_ACTIONS - 1) : 15);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TERM = 1'b1;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

	function automatic logic in_table(input logic [STATE_W-1:0] idx);
		return 32'(idx) < NUM_STATES;
	endfunction

	function automatic logic [ADDR_W-1:0] to_addr(input logic [STATE_W-1:0] idx);
		return ADDR_W'(idx);
	endfunction

	function automatic logic signed [VALUE_W-1:0] sat_value(
		input logic signed [SUM_W-1:0] x
	);
		logic signed [VALUE_W-1:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[VALUE_W-1:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[VALUE_W-1:0];
		end else begin
			r = x[VALUE_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/ssp_bellman_backup_core.sv]
// Top level of the streaming Bellman backup core (min-cost value iteration).
// Depends on sbb_pkg and sbb_ram.
//
// Channel   Signals                                     Handshake
// -------   -----------------------------------------   ---------------------------
// item in   kind state_index load_value reward          start & !busy at clk edge
//           successor successor_valid probability
//           last_of_action last_of_state
// result    updated_state new_value best_action         done, one cycle, no stall
//
// Cycles: one transaction per clock while busy is low. After a term with
// last_of_state, busy is high for one cycle while the written-back value is
// still being formed. The closing term passes s1 and s2, and the result
// register then raises done with the result. Reset clears the backup state and
// the pipeline valids; the value table holds garbage until loaded. The receiver
// cannot stall: done is a one-cycle strobe.
//
// Pipeline:
//   accept  - issue the table read at the successor address.
//   s1      - pick the freshest value (RAM, last write, pending load), take the
//             magnitude and multiply by the probability.
//   s2      - accumulate with saturation, compare against the best action, store
//             loads; on a state's last term write the minimum back and emit it.
module ssp_bellman_backup_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [sbb_pkg::STATE_W-1:0]   state_index,
	input  logic signed [sbb_pkg::VALUE_W-1:0] load_value,
	input  logic signed [sbb_pkg::VALUE_W-1:0] reward,
	input  logic [sbb_pkg::STATE_W-1:0]   successor,
	input  logic                          successor_valid,
	input  logic [sbb_pkg::PROB_W-1:0]    probability,
	input  logic                          last_of_action,
	input  logic                          last_of_state,
	output logic                          done,
	output logic [sbb_pkg::STATE_W-1:0]   updated_state,
	output logic signed [sbb_pkg::VALUE_W-1:0] new_value,
	output logic [sbb_pkg::ACTION_W-1:0]  best_action
);

	import sbb_pkg::*;

	logic accept;

	// stage 1 registers
	logic                      valid_s1;
	logic                      kind_s1;
	logic [STATE_W-1:0]        sidx_s1;
	logic signed [VALUE_W-1:0] word_s1;
	logic [STATE_W-1:0]        succ_s1;
	logic                      sval_s1;
	logic [PROB_W-1:0]         prob_s1;
	logic                      lact_s1;
	logic                      lst_s1;

	// stage 2 registers
	logic                      valid_s2;
	logic                      kind_s2;
	logic [STATE_W-1:0]        sidx_s2;
	logic signed [VALUE_W-1:0] word_s2;
	logic [PROD_W-1:0]         prod_s2;
	logic                      sval_s2;
	logic                      lact_s2;
	logic                      lst_s2;

	// backup state
	logic signed [VALUE_W-1:0] acc_q;
	logic signed [VALUE_W-1:0] best_q;
	logic [ACTION_W-1:0]       best_idx_q;
	logic [ACTION_W-1:0]       act_cnt_q;
	logic                      open_q;

	// last table write, for the read that raced it
	logic                      lw_valid_q;
	logic [STATE_W-1:0]        lw_idx_q;
	logic [VALUE_W-1:0]        lw_data_q;

	// result register
	logic                      done_q;
	logic [STATE_W-1:0]        upd_state_q;
	logic signed [VALUE_W-1:0] new_value_q;
	logic [ACTION_W-1:0]       best_action_q;

	// table port
	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr;
	logic [VALUE_W-1:0]        ram_wdata;
	logic [VALUE_W-1:0]        ram_rdata;

	// hold off the item right after a state close: its write-back is not formed yet
	assign busy   = valid_s1 & (kind_s1 == KIND_TERM) & lst_s1;
	assign accept = start & ~busy;

	sbb_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (NUM_STATES)
	) u_value_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (to_addr(successor)),
		.rdata (ram_rdata)
	);

	// ---------------- stage 1: forward, magnitude, multiply ----------------
	logic signed [VALUE_W-1:0] succ_val_s1;
	logic [VALUE_W-1:0]        mag_s1;
	logic [FULL_W-1:0]         full_s1;

	always_comb begin
		// newest writer wins: a load sitting in s2, then the write that raced the read
		priority if (!in_table(succ_s1)) begin
			succ_val_s1 = '0;
		end else if (valid_s2 && (kind_s2 == KIND_LOAD) && (sidx_s2 == succ_s1)) begin
			succ_val_s1 = word_s2;
		end else if (lw_valid_q && (lw_idx_q == succ_s1)) begin
			succ_val_s1 = lw_data_q;
		end else begin
			succ_val_s1 = ram_rdata;
		end
		// the most negative value maps to 2^31, which fits unsigned
		mag_s1  = succ_val_s1[VALUE_W-1] ? (~succ_val_s1 + 1'b1) : succ_val_s1;
		full_s1 = FULL_W'(mag_s1) * FULL_W'(prob_s1);
	end

	// ---------------- stage 2: accumulate, select, write back ----------------
	logic signed [VALUE_W-1:0] base_s2;
	logic signed [SUM_W-1:0]   sum_s2;
	logic signed [VALUE_W-1:0] acc_nxt;
	logic                      close_s2;
	logic                      take_s2;
	logic signed [VALUE_W-1:0] best_nxt;
	logic [ACTION_W-1:0]       best_idx_nxt;
	logic                      term_s2;

	always_comb begin
		term_s2  = valid_s2 & (kind_s2 == KIND_TERM);
		base_s2  = open_q ? acc_q : word_s2;
		sum_s2   = SUM_W'(base_s2) + $signed({1'b0, prod_s2});
		acc_nxt  = sval_s2 ? sat_value(sum_s2) : base_s2;
		close_s2 = lact_s2 | lst_s2;
		// first action takes the slot; later ones only when strictly cheaper
		take_s2  = close_s2 & ((act_cnt_q == '0) | (acc_nxt < best_q));
		best_nxt     = take_s2 ? acc_nxt   : best_q;
		best_idx_nxt = take_s2 ? act_cnt_q : best_idx_q;

		ram_we    = valid_s2 & ((kind_s2 == KIND_LOAD) | lst_s2) & in_table(sidx_s2);
		ram_waddr = to_addr(sidx_s2);
		ram_wdata = (kind_s2 == KIND_LOAD) ? word_s2 : best_nxt;
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			lw_valid_q <= 1'b0;
			done_q     <= 1'b0;
			acc_q      <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
			act_cnt_q  <= '0;
			open_q     <= 1'b0;
		end else begin
			valid_s1   <= accept;
			valid_s2   <= valid_s1;
			lw_valid_q <= ram_we;
			done_q     <= term_s2 & lst_s2;
			if (term_s2) begin
				acc_q <= acc_nxt;
				if (lst_s2) begin
					// state done: reset the action scan for the next state
					best_q     <= '0;
					best_idx_q <= '0;
					act_cnt_q  <= '0;
					open_q     <= 1'b0;
				end else begin
					best_q     <= best_nxt;
					best_idx_q <= best_idx_nxt;
					open_q     <= ~close_s2;
					if (close_s2 && (act_cnt_q < ACT_LIMIT)) begin
						act_cnt_q <= act_cnt_q + 1'b1;
					end
				end
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			sidx_s1 <= state_index;
			word_s1 <= (kind == KIND_LOAD) ? load_value : reward;
			succ_s1 <= successor;
			sval_s1 <= successor_valid;
			prob_s1 <= probability;
			lact_s1 <= last_of_action;
			lst_s1  <= last_of_state;
		end
		kind_s2 <= kind_s1;
		sidx_s2 <= sidx_s1;
		word_s2 <= word_s1;
		prod_s2 <= full_s1[FULL_W-1:PROB_SHIFT];
		sval_s2 <= sval_s1;
		lact_s2 <= lact_s1;
		lst_s2  <= lst_s1;

		lw_idx_q  <= sidx_s2;
		lw_data_q <= ram_wdata;

		upd_state_q   <= sidx_s2;
		new_value_q   <= best_nxt;
		best_action_q <= best_idx_nxt;
	end

	assign done          = done_q;
	assign updated_state = upd_state_q;
	assign new_value     = new_value_q;
	assign best_action   = best_action_q;

endmodule

[rtl/core/sbb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents. No dependencies.
module sbb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
